>>> hw/rtl/rcbp_pkg.sv
// Package for the robot command byte parser.
// Field widths, protocol byte codes and configuration register indexes.
// No dependencies.
package rcbp_pkg;

    localparam int BYTE_W  = 8;
    localparam int DIR_W   = 4;
    localparam int SPEED_W = 7;
    localparam int PIDX_W  = 2;
    localparam int PVAL_W  = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] BYTE_SLOW   = 8'h59;
    localparam logic [BYTE_W-1:0] BYTE_FAST   = 8'h58;
    localparam logic [BYTE_W-1:0] DIR_LOW     = 8'h41;
    localparam logic [BYTE_W-1:0] DIR_HIGH    = 8'h48;
    localparam logic [BYTE_W-1:0] DIR_BASE    = 8'h40;
    localparam logic [BYTE_W-1:0] DIR_RAW_MAX = 8'h08;
    localparam logic [BYTE_W-1:0] FRAME_OPEN  = 8'h7B;
    localparam logic [BYTE_W-1:0] FRAME_CLOSE = 8'h7D;
    localparam logic [BYTE_W-1:0] REPORT_MARK = 8'h50;
    localparam logic [BYTE_W-1:0] NO_WRITE_ID = 8'h23;
    localparam logic [BYTE_W-1:0] ID_BASE     = 8'h30;
    localparam logic [BYTE_W-1:0] ID_LAST     = 8'h33;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO  = 8'h30;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED = 1'b1;

    localparam logic [SPEED_W-1:0] SLOW_SPEED_RST = 7'd35;
    localparam logic [SPEED_W-1:0] FAST_SPEED_RST = 7'd70;

endpackage

>>> hw/rtl/rcbp_in_if.sv
// Byte request channel of the robot command byte parser.
// Depends on rcbp_pkg.
interface rcbp_in_if;
    logic                         valid;
    logic                         ready;
    logic [rcbp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/rcbp_out_if.sv
// Result request channel of the robot command byte parser.
// Depends on rcbp_pkg.
interface rcbp_out_if;
    logic                                valid;
    logic                                ready;
    logic [rcbp_pkg::DIR_W-1:0]          direction;
    logic [rcbp_pkg::SPEED_W-1:0]        speed;
    logic                                report_request;
    logic                                param_write;
    logic [rcbp_pkg::PIDX_W-1:0]         param_index;
    logic signed [rcbp_pkg::PVAL_W-1:0]  param_value;

    modport source (output valid, output direction, output speed, output report_request,
                    output param_write, output param_index, output param_value,
                    input ready);
    modport sink   (input valid, input direction, input speed, input report_request,
                    input param_write, input param_index, input param_value,
                    output ready);
endinterface

>>> hw/rtl/robot_command_byte_parser.sv
// Robot command byte parser: top level.
// Depends on rcbp_pkg, rcbp_in_if and rcbp_out_if.
//
// Decodes one received serial byte per request into a direction code, the current
// speed and, on a closing '}', a report request or a tuning parameter write with its
// saturated decimal value. Every byte gives exactly one result. The result of each
// accepted byte is loaded into the output register at the edge that takes the byte;
// bytes are accepted every cycle as long as the output register is empty or being
// read in the same cycle. The frame state and the accumulate-times-ten-and-saturate
// update sit in one registered pass, which sets the clock rate. Configuration writes
// to the speed registers take effect at the next speed select byte.
module robot_command_byte_parser #(
    parameter int FRAME_CAPACITY = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rcbp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rcbp_pkg::SPEED_W-1:0]         i_cfg_data,
    rcbp_in_if.sink                              i_rx,
    rcbp_out_if.source                           o_res
);
    import rcbp_pkg::*;

    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
    localparam int EXT_W = PVAL_W + 5;

    localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(64'sh7FFF_FFFF);
    localparam logic signed [EXT_W-1:0] SAT_MIN = -EXT_W'(64'sh8000_0000);

    logic [SPEED_W-1:0]        r_slow_speed;
    logic [SPEED_W-1:0]        r_fast_speed;
    logic [SPEED_W-1:0]        r_speed, n_speed;
    logic                      r_in_frame, n_in_frame;
    logic [CNT_W-1:0]          r_frame_count, n_frame_count;
    logic [BYTE_W-1:0]         r_id_byte, n_id_byte;
    logic [BYTE_W-1:0]         r_third_byte, n_third_byte;
    logic signed [PVAL_W-1:0]  r_acc, n_acc;

    logic                      r_out_valid;
    logic [DIR_W-1:0]          r_dir, n_dir;
    logic [SPEED_W-1:0]        r_out_speed;
    logic                      r_report, n_report;
    logic                      r_pwrite, n_pwrite;
    logic [PIDX_W-1:0]         r_pidx, n_pidx;
    logic signed [PVAL_W-1:0]  r_pval, n_pval;

    logic                      in_ready;
    logic                      accept;
    logic [BYTE_W-1:0]         b;
    logic signed [EXT_W-1:0]   acc_ext;
    logic signed [EXT_W-1:0]   fold_sum;
    logic signed [PVAL_W-1:0]  fold_sat;
    logic                      collect;

    assign in_ready   = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && in_ready;
    assign i_rx.ready = in_ready;
    assign b          = i_rx.rx_byte;

    // acc*10 + (b - '0') in extended precision, then clamp to 32 bits signed
    always_comb begin
        acc_ext  = EXT_W'(r_acc);
        fold_sum = (acc_ext <<< 3) + (acc_ext <<< 1)
                 + $signed({{(EXT_W-BYTE_W){1'b0}}, b})
                 - $signed({{(EXT_W-BYTE_W){1'b0}}, DIGIT_ZERO});
        if (fold_sum > SAT_MAX) begin
            fold_sat = SAT_MAX[PVAL_W-1:0];
        end else if (fold_sum < SAT_MIN) begin
            fold_sat = SAT_MIN[PVAL_W-1:0];
        end else begin
            fold_sat = fold_sum[PVAL_W-1:0];
        end
    end

    always_comb begin
        n_speed       = r_speed;
        n_in_frame    = r_in_frame;
        n_frame_count = r_frame_count;
        n_id_byte     = r_id_byte;
        n_third_byte  = r_third_byte;
        n_acc         = r_acc;
        n_report      = 1'b0;
        n_pwrite      = 1'b0;
        n_pidx        = '0;
        n_pval        = '0;
        collect       = 1'b0;

        if (b == BYTE_SLOW) begin
            n_speed = r_slow_speed;
        end else if (b == BYTE_FAST) begin
            n_speed = r_fast_speed;
        end

        if (b >= DIR_LOW && b <= DIR_HIGH) begin
            n_dir = DIR_W'(b - DIR_BASE);
        end else if (b <= DIR_RAW_MAX) begin
            n_dir = b[DIR_W-1:0];
        end else begin
            n_dir = '0;
        end

        if (b == FRAME_OPEN) begin
            n_in_frame = 1'b1;
        end

        if (b == FRAME_CLOSE) begin
            if (r_third_byte == REPORT_MARK) begin
                n_report = 1'b1;
            end else if (r_id_byte != NO_WRITE_ID && r_id_byte >= ID_BASE
                         && r_id_byte <= ID_LAST) begin
                n_pwrite = 1'b1;
                n_pidx   = PIDX_W'(r_id_byte - ID_BASE);
                n_pval   = r_acc;
            end
            n_in_frame    = 1'b0;
            n_frame_count = '0;
            n_id_byte     = '0;
            n_third_byte  = '0;
            n_acc         = '0;
        end else begin
            collect = n_in_frame && (r_frame_count < CNT_W'(FRAME_CAPACITY));
            if (collect) begin
                if (r_frame_count == CNT_W'(1)) begin
                    n_id_byte = b;
                end
                if (r_frame_count == CNT_W'(3)) begin
                    n_third_byte = b;
                end
                if (r_frame_count >= CNT_W'(3)) begin
                    n_acc = fold_sat;
                end
                n_frame_count = r_frame_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_speed <= SLOW_SPEED_RST;
            r_fast_speed <= FAST_SPEED_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SLOW_SPEED) begin
                r_slow_speed <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_FAST_SPEED) begin
                r_fast_speed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed       <= FAST_SPEED_RST;
            r_in_frame    <= 1'b0;
            r_frame_count <= '0;
            r_id_byte     <= '0;
            r_third_byte  <= '0;
            r_acc         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_speed       <= n_speed;
                r_in_frame    <= n_in_frame;
                r_frame_count <= n_frame_count;
                r_id_byte     <= n_id_byte;
                r_third_byte  <= n_third_byte;
                r_acc         <= n_acc;
                r_out_valid   <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dir       <= n_dir;
            r_out_speed <= n_speed;
            r_report    <= n_report;
            r_pwrite    <= n_pwrite;
            r_pidx      <= n_pidx;
            r_pval      <= n_pval;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.direction      = r_dir;
    assign o_res.speed          = r_out_speed;
    assign o_res.report_request = r_report;
    assign o_res.param_write    = r_pwrite;
    assign o_res.param_index    = r_pidx;
    assign o_res.param_value    = r_pval;

    a_report_xor_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_report && r_pwrite))
        else $error("report and parameter write raised together");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && b == FRAME_CLOSE) |=> (!r_in_frame && r_frame_count == '0
                                          && r_acc == '0))
        else $error("frame state not cleared after close");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_count <= CNT_W'(FRAME_CAPACITY))
        else $error("frame count beyond capacity");

    a_count_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_frame_count == '0))
        else $error("frame count set outside a frame");

endmodule

>>> test/rcbp_result_checker.sv
// Result checker for the robot command byte parser testbench.
// Watches the byte and result channels and the config port, predicts each result
// and compares it. Depends on rcbp_pkg, rcbp_in_if and rcbp_out_if.
module rcbp_result_checker
    import rcbp_pkg::*;
#(
    parameter int FRAME_CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SPEED_W-1:0]   i_cfg_data,
    rcbp_in_if                   i_rx,
    rcbp_out_if                  i_res,
    output int                   o_failures,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [DIR_W-1:0]         direction;
        logic [SPEED_W-1:0]       speed;
        logic                     report_request;
        logic                     param_write;
        logic [PIDX_W-1:0]        param_index;
        logic signed [PVAL_W-1:0] param_value;
    } t_parser_result;

    t_parser_result pending_results[$];

    logic [SPEED_W-1:0]       slow_cfg;
    logic [SPEED_W-1:0]       fast_cfg;
    logic [SPEED_W-1:0]       speed_sel;
    logic                     framing;
    logic [6:0]               frame_cnt;
    logic [BYTE_W-1:0]        id_kept;
    logic [BYTE_W-1:0]        third_kept;
    logic signed [PVAL_W-1:0] decimal_acc;

    task automatic flag_mismatch(input string field, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
        $display("%0t ns: %s got %0d, expected %0d", $time, field, got, want);
        o_failures++;
    endtask

    task automatic clear_frame();
        framing     = 1'b0;
        frame_cnt   = '0;
        id_kept     = '0;
        third_kept  = '0;
        decimal_acc = '0;
    endtask

    task automatic decode_rx_byte(input logic [BYTE_W-1:0] b, output t_parser_result r);
        longint folded;
        r = '0;
        if (b == BYTE_SLOW)
            speed_sel = slow_cfg;
        else if (b == BYTE_FAST)
            speed_sel = fast_cfg;

        if (b >= DIR_LOW && b <= DIR_HIGH)
            r.direction = DIR_W'(b - DIR_BASE);
        else if (b <= DIR_RAW_MAX)
            r.direction = DIR_W'(b);

        if (b == FRAME_OPEN)
            framing = 1'b1;

        if (b == FRAME_CLOSE) begin
            if (third_kept == REPORT_MARK) begin
                r.report_request = 1'b1;
            end else if (id_kept != NO_WRITE_ID && id_kept >= ID_BASE && id_kept <= ID_LAST) begin
                r.param_write = 1'b1;
                r.param_index = PIDX_W'(id_kept - ID_BASE);
                r.param_value = decimal_acc;
            end
            clear_frame();
        end else if (framing && int'(frame_cnt) < FRAME_CAPACITY) begin
            if (frame_cnt == 7'd1)
                id_kept = b;
            if (frame_cnt == 7'd3)
                third_kept = b;
            if (frame_cnt >= 7'd3) begin
                folded = longint'(decimal_acc) * 10 + longint'(b) - longint'(DIGIT_ZERO);
                if (folded > ACC_MAX)
                    decimal_acc = ACC_MAX[PVAL_W-1:0];
                else if (folded < ACC_MIN)
                    decimal_acc = ACC_MIN[PVAL_W-1:0];
                else
                    decimal_acc = folded[PVAL_W-1:0];
            end
            frame_cnt = frame_cnt + 7'd1;
        end
        r.speed = speed_sel;
    endtask

    always @(posedge i_clk) begin : monitor
        t_parser_result got;
        t_parser_result want;
        if (!i_rst_n) begin
            slow_cfg   = SLOW_SPEED_RST;
            fast_cfg   = FAST_SPEED_RST;
            speed_sel  = FAST_SPEED_RST;
            o_failures = 0;
            clear_frame();
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLOW_SPEED: slow_cfg = i_cfg_data;
                    CFG_FAST_SPEED: fast_cfg = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_res.valid && i_res.ready) begin
                got = '{i_res.direction, i_res.speed, i_res.report_request,
                        i_res.param_write, i_res.param_index, i_res.param_value};
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result, direction", got.direction, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.direction !== want.direction)
                        flag_mismatch("direction", got.direction, want.direction);
                    if (got.speed !== want.speed)
                        flag_mismatch("speed", got.speed, want.speed);
                    if (got.report_request !== want.report_request)
                        flag_mismatch("report_request", got.report_request,
                                      want.report_request);
                    if (got.param_write !== want.param_write)
                        flag_mismatch("param_write", got.param_write, want.param_write);
                    if (got.param_index !== want.param_index)
                        flag_mismatch("param_index", got.param_index, want.param_index);
                    if (got.param_value !== want.param_value)
                        flag_mismatch("param_value", got.param_value, want.param_value);
                end
            end

            if (i_rx.valid && i_rx.ready) begin
                decode_rx_byte(i_rx.rx_byte, want);
                pending_results.push_back(want);
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

>>> test/tb_robot_command_byte_parser.sv
// Testbench top for the robot command byte parser.
// Drives bytes, config writes and result backpressure; rcbp_result_checker predicts
// and compares. Depends on rcbp_pkg, rcbp_in_if, rcbp_out_if and the parser RTL.
module tb_robot_command_byte_parser;
    import rcbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_CAPACITY = 64;
    localparam int PHASE_ITEMS    = 135;
    localparam int DIRECTED_ITEMS = 30;
    localparam int DRAIN_CYCLES   = 4;
    localparam int QUIET_LIMIT    = 2000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [SPEED_W-1:0]   cfg_data;

    int gap_pct;
    int stall_pct;
    int sent_items;
    int failures;
    int pending;

    rcbp_in_if  rx_if ();
    rcbp_out_if res_if ();

    robot_command_byte_parser #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_if),
        .o_res      (res_if)
    );

    rcbp_result_checker #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_if),
        .i_res      (res_if),
        .o_failures (failures),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // All tasks start and end in the time step right after a rising edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < gap_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_results_drained();
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] body_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(255));
        return (b == FRAME_CLOSE) ? FRAME_OPEN : b;
    endfunction

    // A sinking frame feeds bytes below '0' to drive the value toward negative saturation.
    function automatic logic [BYTE_W-1:0] digit_byte(input bit sinking);
        if (sinking)
            return BYTE_W'($urandom_range(47));
        return DIGIT_ZERO + BYTE_W'($urandom_range(9));
    endfunction

    task automatic send_random_frame();
        int  pick;
        int  tail_len;
        bit  sinking;
        sinking = ($urandom_range(9) == 0);
        send_byte(FRAME_OPEN);
        pick = $urandom_range(99);
        if (pick < 60)
            send_byte(ID_BASE + BYTE_W'($urandom_range(3)));
        else if (pick < 75)
            send_byte(NO_WRITE_ID);
        else
            send_byte(body_byte());
        send_byte(body_byte());
        pick = $urandom_range(99);
        if (pick < 20)
            send_byte(REPORT_MARK);
        else if (pick < 85)
            send_byte(digit_byte(sinking));
        else
            send_byte(body_byte());
        tail_len = ($urandom_range(19) == 0) ? $urandom_range(70, 55) : $urandom_range(12);
        repeat (tail_len) begin
            pick = $urandom_range(99);
            if (pick < 88)
                send_byte(digit_byte(sinking));
            else if (pick < 95)
                send_byte(body_byte());
            else
                send_byte(($urandom_range(1) == 0) ? BYTE_SLOW : BYTE_FAST);
        end
        if ($urandom_range(19) != 0)
            send_byte(FRAME_CLOSE);
    endtask

    task automatic send_random_single();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            send_byte(BYTE_W'($urandom_range(255)));
        else if (pick < 55)
            send_byte(BYTE_W'($urandom_range(8)));
        else if (pick < 65)
            send_byte(DIR_LOW + BYTE_W'($urandom_range(7)));
        else if (pick < 80)
            send_byte(($urandom_range(1) == 0) ? BYTE_SLOW : BYTE_FAST);
        else
            send_byte(FRAME_CLOSE);
    endtask

    initial begin : stimulus
        int pick;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_SLOW_SPEED;
        cfg_data      = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        sent_items    = 0;
        i_rst_n       = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: direction extremes, speed selects at reset values, lone close,
        // report frame, nested open with negative value, no-write id
        send_byte(FRAME_CLOSE);
        send_byte(8'h00);
        send_byte(DIR_RAW_MAX);
        send_byte(8'h09);
        send_byte(DIR_LOW);
        send_byte(DIR_HIGH);
        send_byte(8'hFF);
        send_byte(BYTE_SLOW);
        send_byte(BYTE_FAST);
        send_text("{1xP}");
        send_text("{2{-7}");
        send_text("{#5}");
        wait_results_drained();

        for (int phase = 0; phase < 4; phase++) begin
            wait_results_drained();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            case (phase)
                0: begin
                    gap_pct = 0;
                    stall_pct = 0;
                    write_cfg(CFG_SLOW_SPEED, 7'd0);
                    write_cfg(CFG_FAST_SPEED, 7'd127);
                end
                1: begin
                    gap_pct = 67;
                    stall_pct = 0;
                    write_cfg(CFG_SLOW_SPEED, 7'd127);
                    write_cfg(CFG_FAST_SPEED, 7'd0);
                end
                2: begin
                    gap_pct = 0;
                    stall_pct = 67;
                    write_cfg(CFG_SLOW_SPEED, SPEED_W'($urandom_range(127)));
                    write_cfg(CFG_FAST_SPEED, SPEED_W'($urandom_range(127)));
                end
                default: begin
                    gap_pct = 13;
                    stall_pct = 13;
                    write_cfg(CFG_FAST_SPEED, SPEED_W'($urandom_range(127)));
                    write_cfg(CFG_SLOW_SPEED, SPEED_W'($urandom_range(127)));
                end
            endcase
            send_byte(BYTE_SLOW);
            send_byte(BYTE_FAST);
            while (sent_items < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 3)
                    wait_results_drained();
                else if (pick < 58)
                    send_random_frame();
                else
                    send_random_single();
            end
        end

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (failures == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
